// ----- rtl/rmse_pkg.sv -----
`default_nettype none

package rmse_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int ERR_W        = 16;
    localparam int SQ_W         = 2 * ERR_W;
    localparam int SUM_W        = 42;
    localparam int CNT_W        = 11;
    localparam int ROOT_W       = SUM_W / 2;
    localparam int RMS_W        = 16;
    localparam int NUM_AXES     = 3;
    localparam int MAX_WINDOW   = 1024;
    localparam int WINDOW_RESET = 1000;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int TDATA_IN_W   = NUM_AXES * SAMPLE_W;
    localparam int TDATA_OUT_W  = NUM_AXES * (ERR_W + RMS_W);
    localparam int TUSER_OUT_W  = 2;

    localparam int DIV_STEPS  = SUM_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_STEPS - 1);
    localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(SQRT_STEPS - 1);

    localparam logic [CNT_W-1:0] WIN_MAX   = CNT_W'(MAX_WINDOW);
    localparam logic [CNT_W-1:0] WIN_RESET = CNT_W'(WINDOW_RESET);

    localparam logic ACT_SAMPLE  = 1'b0;
    localparam logic ACT_REPORT  = 1'b1;
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REF_X  = 2'd0,
        CFG_REF_Y  = 2'd1,
        CFG_REF_Z  = 2'd2,
        CFG_WINDOW = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_DIV,
        ST_SQRT,
        ST_REPORT
    } rmse_state_t;

    typedef struct packed {
        logic capture;
        logic square;
        logic accum;
        logic div_load;
        logic div_step;
        logic sqrt_step;
        logic load_out;
        logic report;
        logic clear_win;
    } rmse_cmd_t;

    typedef struct packed {
        logic win_full;
        logic out_free;
    } rmse_status_t;

endpackage

`default_nettype wire

// ----- rtl/rmse_lane.sv -----
`default_nettype none

module rmse_lane (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic signed [rmse_pkg::SAMPLE_W-1:0] ref_value,
    input  wire logic signed [rmse_pkg::SAMPLE_W-1:0] sample,
    input  wire rmse_pkg::rmse_cmd_t                 cmd,
    input  wire logic                                clear,
    input  wire logic        [rmse_pkg::CNT_W-1:0]    count,
    output logic             [rmse_pkg::ERR_W-1:0]    err,
    output logic             [rmse_pkg::RMS_W-1:0]    rms
);
    import rmse_pkg::*;

    logic signed [SAMPLE_W:0] diff;
    logic        [SAMPLE_W:0] mag;
    logic        [ERR_W-1:0]  err_sat;
    logic        [SQ_W-1:0]   sq;

    logic [ERR_W-1:0]  err_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  drem_reg;
    logic [ROOT_W:0]   srem_reg;
    logic [ROOT_W-1:0] root_reg;

    logic [CNT_W:0]    div_trial;
    logic              div_ge;
    logic [CNT_W-1:0]  drem_next;
    logic [ROOT_W+2:0] sqrt_rem4;
    logic [ROOT_W+2:0] sqrt_trial;
    logic              sqrt_ge;
    logic [ROOT_W:0]   srem_next;

    always_comb begin
        diff    = $signed({ref_value[SAMPLE_W-1], ref_value}) - $signed({sample[SAMPLE_W-1], sample});
        mag     = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : $unsigned(diff);
        err_sat = (|mag[SAMPLE_W:ERR_W]) ? '1 : mag[ERR_W-1:0];
        sq      = SQ_W'(err_sat) * SQ_W'(err_sat);
    end

    // Restoring divide, one quotient bit per cycle.
    always_comb begin
        div_trial = {drem_reg, quo_reg[SUM_W-1]};
        div_ge    = (div_trial >= {1'b0, count});
        drem_next = div_ge ? CNT_W'(div_trial - {1'b0, count}) : div_trial[CNT_W-1:0];
    end

    // Digit-by-digit square root, two radicand bits per cycle.
    always_comb begin
        sqrt_rem4  = {srem_reg, quo_reg[SUM_W-1 -: 2]};
        sqrt_trial = {1'b0, root_reg, 2'b01};
        sqrt_ge    = (sqrt_rem4 >= sqrt_trial);
        srem_next  = sqrt_ge ? (ROOT_W+1)'(sqrt_rem4 - sqrt_trial) : sqrt_rem4[ROOT_W:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (clear) begin
            sum_reg <= '0;
        end else if (cmd.accum) begin
            sum_reg <= sum_reg + SUM_W'(sq_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.square) begin
            err_reg <= err_sat;
            sq_reg  <= sq;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            quo_reg  <= sum_reg;
            drem_reg <= '0;
            srem_reg <= '0;
            root_reg <= '0;
        end else if (cmd.div_step) begin
            quo_reg  <= {quo_reg[SUM_W-2:0], div_ge};
            drem_reg <= drem_next;
        end else if (cmd.sqrt_step) begin
            quo_reg  <= {quo_reg[SUM_W-3:0], 2'b00};
            srem_reg <= srem_next;
            root_reg <= {root_reg[ROOT_W-2:0], sqrt_ge};
        end
    end

    assign err = err_reg;
    assign rms = (|root_reg[ROOT_W-1:RMS_W]) ? '1 : root_reg[RMS_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/rmse_datapath.sv -----
`default_nettype none

module rmse_datapath (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic        [rmse_pkg::TDATA_IN_W-1:0]  in_data,
    input  wire logic signed [rmse_pkg::SAMPLE_W-1:0]    ref_x,
    input  wire logic signed [rmse_pkg::SAMPLE_W-1:0]    ref_y,
    input  wire logic signed [rmse_pkg::SAMPLE_W-1:0]    ref_z,
    input  wire logic        [rmse_pkg::CNT_W-1:0]       window_length,
    input  wire logic                                   cfg_clear,
    input  wire rmse_pkg::rmse_cmd_t                    cmd,
    output rmse_pkg::rmse_status_t                      status,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic             [rmse_pkg::TDATA_OUT_W-1:0] m_tdata,
    output logic             [rmse_pkg::TUSER_OUT_W-1:0] m_tuser
);
    import rmse_pkg::*;

    logic signed [SAMPLE_W-1:0] samp_reg [NUM_AXES];
    logic signed [SAMPLE_W-1:0] ref_arr  [NUM_AXES];
    logic        [ERR_W-1:0]    err_w    [NUM_AXES];
    logic        [RMS_W-1:0]    rms_w    [NUM_AXES];

    logic [CNT_W-1:0] acc_count_reg;
    logic [CNT_W-1:0] win_count_reg;
    logic [CNT_W-1:0] win_eff;
    logic             report_done;
    logic             lane_clear;
    logic             no_samples;

    logic                   m_tvalid_reg;
    logic [TDATA_OUT_W-1:0] out_data_reg;
    logic [TUSER_OUT_W-1:0] out_user_reg;
    logic [TDATA_OUT_W-1:0] out_data_next;

    assign ref_arr[0] = ref_x;
    assign ref_arr[1] = ref_y;
    assign ref_arr[2] = ref_z;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                samp_reg[a] <= $signed(in_data[a*SAMPLE_W +: SAMPLE_W]);
            end
        end
    end

    assign report_done = cmd.load_out && cmd.report;
    assign lane_clear  = report_done || cfg_clear;

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
        rmse_lane u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ref_value (ref_arr[a]),
            .sample    (samp_reg[a]),
            .cmd       (cmd),
            .clear     (lane_clear),
            .count     (acc_count_reg),
            .err       (err_w[a]),
            .rms       (rms_w[a])
        );
    end

    always_comb begin
        if (window_length == '0) begin
            win_eff = CNT_W'(1);
        end else if (window_length > WIN_MAX) begin
            win_eff = WIN_MAX;
        end else begin
            win_eff = window_length;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_count_reg <= '0;
            win_count_reg <= '0;
        end else begin
            if (lane_clear) begin
                acc_count_reg <= '0;
            end else if (cmd.accum) begin
                acc_count_reg <= acc_count_reg + CNT_W'(1);
            end
            if (report_done && cmd.clear_win) begin
                win_count_reg <= '0;
            end else if (cmd.accum) begin
                win_count_reg <= win_count_reg + CNT_W'(1);
            end
        end
    end

    assign no_samples = (acc_count_reg == '0);

    always_comb begin
        out_data_next = '0;
        for (int a = 0; a < NUM_AXES; a++) begin
            if (cmd.report) begin
                if (!no_samples) begin
                    out_data_next[(NUM_AXES+a)*RMS_W +: RMS_W] = rms_w[a];
                end
            end else begin
                out_data_next[a*ERR_W +: ERR_W] = err_w[a];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg <= out_data_next;
            out_user_reg <= cmd.report ? {no_samples, KIND_REPORT} : {1'b0, KIND_SAMPLE};
        end
    end

    assign status.out_free = !m_tvalid_reg || m_tready;
    assign status.win_full = (win_count_reg >= win_eff);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

`ifndef SYNTHESIS
    a_acc_within_window: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_count_reg <= win_count_reg)
        else $error("accumulated count exceeds window count");

    a_window_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        win_count_reg <= WIN_MAX)
        else $error("window count beyond maximum window");

    a_load_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_tvalid_reg)
        else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire

// ----- rtl/rmse_ctrl.sv -----
`default_nettype none

module rmse_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    input  wire logic                   in_action,
    output logic                        in_ready,
    input  wire rmse_pkg::rmse_status_t status,
    output rmse_pkg::rmse_cmd_t         cmd
);
    import rmse_pkg::*;

    rmse_state_t       state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              win_rep_reg, win_rep_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            win_rep_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            win_rep_reg <= win_rep_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        win_rep_next = win_rep_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    if (in_action == ACT_REPORT || status.win_full) begin
                        cmd.div_load = 1'b1;
                        win_rep_next = (in_action != ACT_REPORT);
                        step_next    = '0;
                        state_next   = ST_DIV;
                    end else begin
                        state_next = ST_SQUARE;
                    end
                end
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                if (status.out_free) begin
                    cmd.accum    = 1'b1;
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (step_reg == DIV_LAST) begin
                    step_next  = '0;
                    state_next = ST_SQRT;
                end else begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (step_reg == SQRT_LAST) begin
                    step_next  = '0;
                    state_next = ST_REPORT;
                end else begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_REPORT: begin
                cmd.report    = 1'b1;
                cmd.clear_win = win_rep_reg;
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_load_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> status.out_free)
        else $error("result loaded while output register is occupied");

    a_div_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (step_reg <= DIV_LAST))
        else $error("divide step count out of range");
`endif

endmodule

`default_nettype wire

// ----- rtl/three_axis_rms_error_meter_core.sv -----
`default_nettype none
// A sample transfer gives its error result after states SQUARE and ACCUM; a report
// (action or full window) gives its RMS result after states DIV, SQRT and REPORT.
// ACCUM and REPORT wait while the output register is busy; no new transfer is taken until
// the last is through. Report time is set by each axis's restoring divider and square root.
// Reset (aresetn low, synchronous) clears sums and counts, sets references to 0 and the
// window length to 1000.

module three_axis_rms_error_meter_core (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // sample_x, sample_y, sample_z
    input  wire logic [rmse_pkg::TDATA_IN_W-1:0]         s_tdata,
    // action
    input  wire logic                                   s_tuser,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // error_x, error_y, error_z, rms_x, rms_y, rms_z
    output logic      [rmse_pkg::TDATA_OUT_W-1:0]        m_tdata,
    // result_kind, no_samples
    output logic      [rmse_pkg::TUSER_OUT_W-1:0]        m_tuser,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [rmse_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [rmse_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import rmse_pkg::*;

    logic signed [SAMPLE_W-1:0] ref_x_reg;
    logic signed [SAMPLE_W-1:0] ref_y_reg;
    logic signed [SAMPLE_W-1:0] ref_z_reg;
    logic        [CNT_W-1:0]    window_reg;
    logic                       cfg_write;
    logic                       cfg_clear;
    rmse_cmd_t                  cmd;
    rmse_status_t               status;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign cfg_clear = cfg_write && (cfg_index inside {CFG_REF_X, CFG_REF_Y, CFG_REF_Z});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_x_reg  <= '0;
            ref_y_reg  <= '0;
            ref_z_reg  <= '0;
            window_reg <= WIN_RESET;
        end else if (cfg_write) begin
            case (cfg_index_t'(cfg_index))
                CFG_REF_X:  ref_x_reg  <= $signed(cfg_data[SAMPLE_W-1:0]);
                CFG_REF_Y:  ref_y_reg  <= $signed(cfg_data[SAMPLE_W-1:0]);
                CFG_REF_Z:  ref_z_reg  <= $signed(cfg_data[SAMPLE_W-1:0]);
                CFG_WINDOW: window_reg <= cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    rmse_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_action (s_tuser),
        .in_ready  (s_tready),
        .status    (status),
        .cmd       (cmd)
    );

    rmse_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_data       (s_tdata),
        .ref_x         (ref_x_reg),
        .ref_y         (ref_y_reg),
        .ref_z         (ref_z_reg),
        .window_length (window_reg),
        .cfg_clear     (cfg_clear),
        .cmd           (cmd),
        .status        (status),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser)
    );

endmodule

`default_nettype wire
